>>> rtl/poi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Planar odometry integrator package
// Shared constants, datapath command codes and arithmetic helpers.
// ----------------------------------------------------------------------------
package poi_pkg;

  localparam logic [19:0] MAX_GAP_RESET = 20'd104858;

  localparam logic signed [22:0] PI_Q16     = 23'sd205887;
  localparam logic signed [22:0] NEG_PI_Q16 = -23'sd205887;
  localparam logic signed [22:0] TWO_PI_Q16 = 23'sd411775;

  localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
  localparam logic [31:0] PI_Q30      = 32'd3373259426;
  localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
  localparam logic [31:0] ROUND_Q14   = 32'd8192;

  localparam logic [1:0] ST_INTEG = 2'd0;
  localparam logic [1:0] ST_FIRST = 2'd1;
  localparam logic [1:0] ST_GAP   = 2'd2;
  localparam logic [1:0] ST_POSE  = 2'd3;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_SIMPLE,
    CMD_REDUCE,
    CMD_MUL_RR,
    CMD_R2,
    CMD_H_MUL,
    CMD_H_RCP,
    CMD_H_QUO,
    CMD_H_UPD,
    CMD_MUL_SR,
    CMD_SV,
    CMD_SC,
    CMD_V1,
    CMD_V2,
    CMD_V3,
    CMD_V4,
    CMD_V5,
    CMD_GX1,
    CMD_GX2,
    CMD_GX3,
    CMD_GY1,
    CMD_GY2,
    CMD_GY3,
    CMD_W1,
    CMD_COMMIT,
    CMD_PUBLISH
  } cmd_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [2:0] k;
    logic       use_cos;
  } ctl_t;

  // floor(2^32 / d) for the Horner divisors
  function automatic logic [31:0] horner_recip(input logic use_cos, input logic [2:0] k);
    logic [31:0] m;
    case ({use_cos, k})
      4'h0: m = 32'd715827882;
      4'h1: m = 32'd214748364;
      4'h2: m = 32'd102261126;
      4'h3: m = 32'd59652323;
      4'h4: m = 32'd39045157;
      4'h5: m = 32'd27531841;
      4'h6: m = 32'd20452225;
      4'h7: m = 32'd15790320;
      4'h8: m = 32'd2147483648;
      4'h9: m = 32'd357913941;
      4'hA: m = 32'd143165576;
      4'hB: m = 32'd76695844;
      4'hC: m = 32'd47721858;
      4'hD: m = 32'd32537631;
      4'hE: m = 32'd23598721;
      default: m = 32'd17895697;
    endcase
    return m;
  endfunction

  function automatic logic [8:0] horner_div(input logic use_cos, input logic [2:0] k);
    logic [8:0] d;
    case ({use_cos, k})
      4'h0: d = 9'd6;
      4'h1: d = 9'd20;
      4'h2: d = 9'd42;
      4'h3: d = 9'd72;
      4'h4: d = 9'd110;
      4'h5: d = 9'd156;
      4'h6: d = 9'd210;
      4'h7: d = 9'd272;
      4'h8: d = 9'd2;
      4'h9: d = 9'd12;
      4'hA: d = 9'd30;
      4'hB: d = 9'd56;
      4'hC: d = 9'd90;
      4'hD: d = 9'd132;
      4'hE: d = 9'd182;
      default: d = 9'd240;
    endcase
    return d;
  endfunction

  function automatic logic signed [18:0] wrap_heading(input logic signed [22:0] h);
    logic signed [22:0] w;
    w = h;
    if (w > PI_Q16) begin
      w = w - TWO_PI_Q16;
    end else if (w < NEG_PI_Q16) begin
      w = w + TWO_PI_Q16;
    end
    if (w > PI_Q16) begin
      w = PI_Q16;
    end
    if (w < NEG_PI_Q16) begin
      w = NEG_PI_Q16;
    end
    return w[18:0];
  endfunction

endpackage

>>> rtl/poi_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Planar odometry integrator controller
// Sequences the shared multiplier, the Horner steps and the result handshake.
// ----------------------------------------------------------------------------
module poi_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  logic          need_integ,
  output poi_pkg::ctl_t ctl
);

  typedef enum logic [24:0] {
    S_IDLE    = 25'h0000001,
    S_DECIDE  = 25'h0000002,
    S_RR      = 25'h0000004,
    S_R2      = 25'h0000008,
    S_HMUL    = 25'h0000010,
    S_HRCP    = 25'h0000020,
    S_HQUO    = 25'h0000040,
    S_HUPD    = 25'h0000080,
    S_MSR     = 25'h0000100,
    S_SV      = 25'h0000200,
    S_SC      = 25'h0000400,
    S_V1      = 25'h0000800,
    S_V2      = 25'h0001000,
    S_V3      = 25'h0002000,
    S_V4      = 25'h0004000,
    S_V5      = 25'h0008000,
    S_GX1     = 25'h0010000,
    S_GX2     = 25'h0020000,
    S_GX3     = 25'h0040000,
    S_GY1     = 25'h0080000,
    S_GY2     = 25'h0100000,
    S_GY3     = 25'h0200000,
    S_W1      = 25'h0400000,
    S_COMMIT  = 25'h0800000,
    S_PUBLISH = 25'h1000000
  } state_t;

  state_t       state, state_next;
  logic [2:0]   k, k_next;
  logic         use_cos, use_cos_next;
  poi_pkg::cmd_t cmd;

  assign in_ready    = (state == S_IDLE);
  assign ctl.cmd     = cmd;
  assign ctl.k       = k;
  assign ctl.use_cos = use_cos;

  always_comb begin
    state_next   = state;
    k_next       = k;
    use_cos_next = use_cos;
    cmd          = poi_pkg::CMD_NONE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd        = poi_pkg::CMD_LOAD;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (need_integ) begin
          cmd        = poi_pkg::CMD_REDUCE;
          state_next = S_RR;
        end else begin
          cmd        = poi_pkg::CMD_SIMPLE;
          state_next = S_PUBLISH;
        end
      end
      S_RR: begin
        cmd        = poi_pkg::CMD_MUL_RR;
        state_next = S_R2;
      end
      S_R2: begin
        cmd          = poi_pkg::CMD_R2;
        k_next       = 3'd7;
        use_cos_next = 1'b0;
        state_next   = S_HMUL;
      end
      S_HMUL: begin
        cmd        = poi_pkg::CMD_H_MUL;
        state_next = S_HRCP;
      end
      S_HRCP: begin
        cmd        = poi_pkg::CMD_H_RCP;
        state_next = S_HQUO;
      end
      S_HQUO: begin
        cmd        = poi_pkg::CMD_H_QUO;
        state_next = S_HUPD;
      end
      S_HUPD: begin
        cmd = poi_pkg::CMD_H_UPD;
        if (k == 3'd0) begin
          state_next = use_cos ? S_SC : S_MSR;
        end else begin
          k_next     = k - 3'd1;
          state_next = S_HMUL;
        end
      end
      S_MSR: begin
        cmd        = poi_pkg::CMD_MUL_SR;
        state_next = S_SV;
      end
      S_SV: begin
        cmd          = poi_pkg::CMD_SV;
        k_next       = 3'd7;
        use_cos_next = 1'b1;
        state_next   = S_HMUL;
      end
      S_SC: begin
        cmd        = poi_pkg::CMD_SC;
        state_next = S_V1;
      end
      S_V1: begin
        cmd        = poi_pkg::CMD_V1;
        state_next = S_V2;
      end
      S_V2: begin
        cmd        = poi_pkg::CMD_V2;
        state_next = S_V3;
      end
      S_V3: begin
        cmd        = poi_pkg::CMD_V3;
        state_next = S_V4;
      end
      S_V4: begin
        cmd        = poi_pkg::CMD_V4;
        state_next = S_V5;
      end
      S_V5: begin
        cmd        = poi_pkg::CMD_V5;
        state_next = S_GX1;
      end
      S_GX1: begin
        cmd        = poi_pkg::CMD_GX1;
        state_next = S_GX2;
      end
      S_GX2: begin
        cmd        = poi_pkg::CMD_GX2;
        state_next = S_GX3;
      end
      S_GX3: begin
        cmd        = poi_pkg::CMD_GX3;
        state_next = S_GY1;
      end
      S_GY1: begin
        cmd        = poi_pkg::CMD_GY1;
        state_next = S_GY2;
      end
      S_GY2: begin
        cmd        = poi_pkg::CMD_GY2;
        state_next = S_GY3;
      end
      S_GY3: begin
        cmd        = poi_pkg::CMD_GY3;
        state_next = S_W1;
      end
      S_W1: begin
        cmd        = poi_pkg::CMD_W1;
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        cmd        = poi_pkg::CMD_COMMIT;
        state_next = S_PUBLISH;
      end
      S_PUBLISH: begin
        if (!out_valid || out_ready) begin
          cmd        = poi_pkg::CMD_PUBLISH;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      k         <= 3'd0;
      use_cos   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      k       <= k_next;
      use_cos <= use_cos_next;
      if (cmd == poi_pkg::CMD_PUBLISH) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/poi_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Planar odometry integrator datapath
// Pose state, shared multiplier, sine/cosine Horner unit and result register.
// ----------------------------------------------------------------------------
module poi_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  poi_pkg::ctl_t        ctl,
  output logic                 need_integ,
  input  logic                 cfg_wr_en,
  input  logic [19:0]          cfg_wr_data,
  input  logic                 kind,
  input  logic signed [23:0]   vel_fwd,
  input  logic signed [23:0]   vel_side,
  input  logic signed [20:0]   turn_rate,
  input  logic [39:0]          stamp,
  input  logic signed [39:0]   set_x,
  input  logic signed [39:0]   set_y,
  input  logic signed [19:0]   set_heading,
  output logic signed [39:0]   pos_x_out,
  output logic signed [39:0]   pos_y_out,
  output logic signed [18:0]   heading_out,
  output logic [1:0]           status
);

  logic [19:0]        max_gap;
  logic               in_kind;
  logic signed [23:0] in_vf;
  logic signed [23:0] in_vs;
  logic signed [20:0] in_w;
  logic [39:0]        in_stamp;
  logic [39:0]        in_sx;
  logic [39:0]        in_sy;
  logic signed [19:0] in_sh;

  logic [39:0]        pos_x;
  logic [39:0]        pos_y;
  logic signed [18:0] heading;
  logic [39:0]        last_stamp;
  logic               time_known;
  logic [1:0]         stat;

  logic [19:0]        gap;
  logic [1:0]         quad;
  logic               hneg;
  logic [30:0]        r;
  logic [31:0]        r2;
  logic [30:0]        t;
  logic [31:0]        n;
  logic [31:0]        q0;
  logic [30:0]        sv;
  logic signed [18:0] sin_q;
  logic signed [18:0] cos_q;
  logic signed [43:0] ax;
  logic signed [43:0] ay;
  logic [41:0]        ltmp;
  logic [29:0]        dx;
  logic [29:0]        dy;
  logic signed [67:0] prod;

  logic signed [33:0] mul_a;
  logic signed [33:0] mul_b;
  logic [39:0]        diff;
  logic [18:0]        hmag;
  logic [31:0]        a_red;
  logic [1:0]         q_red;
  logic [31:0]        r_red;
  logic [8:0]         dv;
  logic [40:0]        qd;
  logic [31:0]        rem;
  logic [32:0]        p;
  logic [31:0]        s_rnd;
  logic [31:0]        c_rnd;
  logic signed [18:0] s_abs;
  logic signed [18:0] c_abs;
  logic signed [18:0] rs;
  logic signed [18:0] rc;
  logic [65:0]        gsum;
  logic signed [22:0] h_sum;
  logic signed [22:0] h_set;

  assign diff       = in_stamp - last_stamp;
  assign need_integ = !in_kind && time_known && (in_stamp > last_stamp) &&
                      (diff <= {20'd0, max_gap});

  always_comb begin
    hmag  = heading[18] ? (~heading + 19'd1) : heading;
    a_red = {hmag[17:0], 14'd0};
    if (a_red >= poi_pkg::PI_Q30) begin
      q_red = 2'd2;
      r_red = a_red - poi_pkg::PI_Q30;
    end else if (a_red >= poi_pkg::HALF_PI_Q30) begin
      q_red = 2'd1;
      r_red = a_red - poi_pkg::HALF_PI_Q30;
    end else begin
      q_red = 2'd0;
      r_red = a_red;
    end
  end

  always_comb begin
    dv  = poi_pkg::horner_div(ctl.use_cos, ctl.k);
    qd  = q0 * dv;
    rem = n - qd[31:0];
    p   = (rem >= {23'd0, dv}) ? ({1'b0, q0} + 33'd1) : {1'b0, q0};
  end

  always_comb begin
    s_rnd = {1'b0, sv} + poi_pkg::ROUND_Q14;
    c_rnd = {1'b0, t} + poi_pkg::ROUND_Q14;
    s_abs = {1'b0, s_rnd[31:14]};
    c_abs = {1'b0, c_rnd[31:14]};
    case (quad)
      2'd0: begin
        rs = s_abs;
        rc = c_abs;
      end
      2'd1: begin
        rs = c_abs;
        rc = -s_abs;
      end
      2'd2: begin
        rs = -s_abs;
        rc = -c_abs;
      end
      default: begin
        rs = -c_abs;
        rc = s_abs;
      end
    endcase
    if (hneg) begin
      rs = -rs;
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctl.cmd)
      poi_pkg::CMD_MUL_RR: begin
        mul_a = {3'd0, r};
        mul_b = {3'd0, r};
      end
      poi_pkg::CMD_H_MUL: begin
        mul_a = {3'd0, t};
        mul_b = {2'd0, r2};
      end
      poi_pkg::CMD_H_RCP: begin
        mul_a = {2'd0, prod[61:30]};
        mul_b = {2'd0, poi_pkg::horner_recip(ctl.use_cos, ctl.k)};
      end
      poi_pkg::CMD_MUL_SR: begin
        mul_a = {3'd0, t};
        mul_b = {3'd0, r};
      end
      poi_pkg::CMD_V1: begin
        mul_a = {{10{in_vf[23]}}, in_vf};
        mul_b = {{15{cos_q[18]}}, cos_q};
      end
      poi_pkg::CMD_V2: begin
        mul_a = {{10{in_vs[23]}}, in_vs};
        mul_b = {{15{sin_q[18]}}, sin_q};
      end
      poi_pkg::CMD_V3: begin
        mul_a = {{10{in_vf[23]}}, in_vf};
        mul_b = {{15{sin_q[18]}}, sin_q};
      end
      poi_pkg::CMD_V4: begin
        mul_a = {{10{in_vs[23]}}, in_vs};
        mul_b = {{15{cos_q[18]}}, cos_q};
      end
      poi_pkg::CMD_GX1: begin
        mul_a = {12'd0, ax[21:0]};
        mul_b = {14'd0, gap};
      end
      poi_pkg::CMD_GX2: begin
        mul_a = {{12{ax[43]}}, ax[43:22]};
        mul_b = {14'd0, gap};
      end
      poi_pkg::CMD_GY1: begin
        mul_a = {12'd0, ay[21:0]};
        mul_b = {14'd0, gap};
      end
      poi_pkg::CMD_GY2: begin
        mul_a = {{12{ay[43]}}, ay[43:22]};
        mul_b = {14'd0, gap};
      end
      poi_pkg::CMD_W1: begin
        mul_a = {{13{in_w[20]}}, in_w};
        mul_b = {14'd0, gap};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign gsum  = {prod[43:0], 22'd0} + {24'd0, ltmp};
  assign h_sum = {{4{heading[18]}}, heading} + {{2{prod[40]}}, prod[40:20]};
  assign h_set = {{3{in_sh[19]}}, in_sh};

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (ctl.cmd)
      poi_pkg::CMD_LOAD: begin
        in_kind  <= kind;
        in_vf    <= vel_fwd;
        in_vs    <= vel_side;
        in_w     <= turn_rate;
        in_stamp <= stamp;
        in_sx    <= set_x;
        in_sy    <= set_y;
        in_sh    <= set_heading;
      end
      poi_pkg::CMD_REDUCE: begin
        gap  <= diff[19:0];
        quad <= q_red;
        hneg <= heading[18];
        r    <= r_red[30:0];
      end
      poi_pkg::CMD_R2: begin
        r2 <= prod[61:30];
        t  <= poi_pkg::ONE_Q30;
      end
      poi_pkg::CMD_H_RCP: begin
        n <= prod[61:30];
      end
      poi_pkg::CMD_H_QUO: begin
        q0 <= prod[63:32];
      end
      poi_pkg::CMD_H_UPD: begin
        if (p >= {2'd0, poi_pkg::ONE_Q30}) begin
          t <= '0;
        end else begin
          t <= poi_pkg::ONE_Q30 - p[30:0];
        end
      end
      poi_pkg::CMD_MUL_SR: begin
        t <= poi_pkg::ONE_Q30;
      end
      poi_pkg::CMD_SV: begin
        sv <= prod[60:30];
      end
      poi_pkg::CMD_SC: begin
        sin_q <= rs;
        cos_q <= rc;
      end
      poi_pkg::CMD_V2: begin
        ax <= prod[43:0];
      end
      poi_pkg::CMD_V3: begin
        ax <= ax - prod[43:0];
      end
      poi_pkg::CMD_V4: begin
        ay <= prod[43:0];
      end
      poi_pkg::CMD_V5: begin
        ay <= ay + prod[43:0];
      end
      poi_pkg::CMD_GX2, poi_pkg::CMD_GY2: begin
        ltmp <= prod[41:0];
      end
      poi_pkg::CMD_GX3: begin
        dx <= gsum[65:36];
      end
      poi_pkg::CMD_GY3: begin
        dy <= gsum[65:36];
      end
      poi_pkg::CMD_PUBLISH: begin
        pos_x_out   <= pos_x;
        pos_y_out   <= pos_y;
        heading_out <= heading;
        status      <= stat;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_gap    <= poi_pkg::MAX_GAP_RESET;
      pos_x      <= '0;
      pos_y      <= '0;
      heading    <= '0;
      last_stamp <= '0;
      time_known <= 1'b0;
      stat       <= poi_pkg::ST_INTEG;
    end else begin
      if (cfg_wr_en) begin
        max_gap <= cfg_wr_data;
      end
      case (ctl.cmd)
        poi_pkg::CMD_SIMPLE: begin
          if (in_kind) begin
            pos_x      <= in_sx;
            pos_y      <= in_sy;
            heading    <= poi_pkg::wrap_heading(h_set);
            time_known <= 1'b0;
            stat       <= poi_pkg::ST_POSE;
          end else if (!time_known) begin
            last_stamp <= in_stamp;
            time_known <= 1'b1;
            stat       <= poi_pkg::ST_FIRST;
          end else begin
            last_stamp <= in_stamp;
            stat       <= poi_pkg::ST_GAP;
          end
        end
        poi_pkg::CMD_COMMIT: begin
          pos_x      <= pos_x + {{10{dx[29]}}, dx};
          pos_y      <= pos_y + {{10{dy[29]}}, dy};
          heading    <= poi_pkg::wrap_heading(h_sum);
          last_stamp <= in_stamp;
          stat       <= poi_pkg::ST_INTEG;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

>>> rtl/planar_odometry_integrator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Planar odometry integrator
// Dead reckoning of x, y and heading from timestamped body velocity samples.
// ----------------------------------------------------------------------------
// Sequence: a pose reset, first sample or rejected gap is decided and then published;
//   an integrating sample first runs 16 Horner steps, rotation and commit.
// Throughput: one transaction at a time; the next accept follows the publish, which
//   waits while an unaccepted result is held (one shared multiplier throughout).
// Reset: synchronous; clears pose, time record and restores max_gap.
module planar_odometry_integrator (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [19:0]          cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 kind,
  input  logic signed [23:0]   vel_fwd,
  input  logic signed [23:0]   vel_side,
  input  logic signed [20:0]   turn_rate,
  input  logic [39:0]          stamp,
  input  logic signed [39:0]   set_x,
  input  logic signed [39:0]   set_y,
  input  logic signed [19:0]   set_heading,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [39:0]   pos_x_out,
  output logic signed [39:0]   pos_y_out,
  output logic signed [18:0]   heading_out,
  output logic [1:0]           status
);

  poi_pkg::ctl_t ctl;
  logic          need_integ;

  poi_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .need_integ (need_integ),
    .ctl        (ctl)
  );

  poi_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .need_integ  (need_integ),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .kind        (kind),
    .vel_fwd     (vel_fwd),
    .vel_side    (vel_side),
    .turn_rate   (turn_rate),
    .stamp       (stamp),
    .set_x       (set_x),
    .set_y       (set_y),
    .set_heading (set_heading),
    .pos_x_out   (pos_x_out),
    .pos_y_out   (pos_y_out),
    .heading_out (heading_out),
    .status      (status)
  );

endmodule

>>> verif/planar_odometry_integrator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Planar odometry integrator testbench
// Drives pose resets and timestamped velocity samples through the valid/ready
// input, with bursty traffic and a stalling receiver, under several gap limits
// from zero to full scale. A directed table covers extremes, heading wrap and
// the time-record rules; random sequences follow. Every result is checked
// field by field against typed row values or the dead-reckoning model below.
// ----------------------------------------------------------------------------
module planar_odometry_integrator_test;

  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct {
    logic               kind;
    logic signed [23:0] vf;
    logic signed [23:0] vs;
    logic signed [20:0] w;
    logic [39:0]        stamp;
    logic signed [39:0] sx;
    logic signed [39:0] sy;
    logic signed [19:0] sh;
  } odo_in_t;

  typedef struct {
    logic signed [39:0] x;
    logic signed [39:0] y;
    logic signed [18:0] h;
    logic [1:0]         st;
  } pose_t;

  typedef struct {
    odo_in_t it;
    bit      typed;
    pose_t   pose;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [19:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic kind = 1'b0;
  logic signed [23:0] vel_fwd = '0;
  logic signed [23:0] vel_side = '0;
  logic signed [20:0] turn_rate = '0;
  logic [39:0] stamp = '0;
  logic signed [39:0] set_x = '0;
  logic signed [39:0] set_y = '0;
  logic signed [19:0] set_heading = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [39:0] pos_x_out;
  logic signed [39:0] pos_y_out;
  logic signed [18:0] heading_out;
  logic [1:0] status;

  planar_odometry_integrator i_dut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .vel_fwd(vel_fwd), .vel_side(vel_side), .turn_rate(turn_rate),
    .stamp(stamp), .set_x(set_x), .set_y(set_y), .set_heading(set_heading),
    .out_valid(out_valid), .out_ready(out_ready),
    .pos_x_out(pos_x_out), .pos_y_out(pos_y_out), .heading_out(heading_out),
    .status(status)
  );

  always #5 clk = ~clk;

  // dead-reckoning state
  logic [19:0]        gap_limit;
  logic signed [39:0] odo_x, odo_y;
  logic signed [18:0] odo_h;
  logic [39:0]        odo_last;
  bit                 odo_timed;

  pose_t pose_q[$];
  row_t  dir_rows[$];
  int mismatches = 0;
  int n_items = 0;
  int n_results = 0;
  int status_seen[4] = '{0, 0, 0, 0};
  int idle_cycles = 0;
  int burst_left = 0;
  int gap_max = 4;

  longint unsigned sin_den[8] = '{6, 20, 42, 72, 110, 156, 210, 272};
  longint unsigned cos_den[8] = '{2, 12, 30, 56, 90, 132, 182, 240};

  function automatic logic signed [18:0] fold_heading(input longint hv);
    if (hv > 205887) hv = hv - 411775;
    else if (hv < -205887) hv = hv + 411775;
    if (hv > 205887) hv = 205887;
    if (hv < -205887) hv = -205887;
    return hv[18:0];
  endfunction

  function automatic longint unsigned series(input bit cosine, input longint unsigned r2);
    longint unsigned t, p, d;
    t = 64'd1 << 30;
    for (int k = 7; k >= 0; k--) begin
      d = cosine ? cos_den[k] : sin_den[k];
      p = ((t * r2) >> 30) / d;
      t = (p >= (64'd1 << 30)) ? 64'd0 : (64'd1 << 30) - p;
    end
    return t;
  endfunction

  task automatic rotation(input logic signed [18:0] hd, output longint sn, output longint cs);
    longint unsigned mag, a, q, r, r2, sv, cv;
    longint s, c;
    mag = (hd < 0) ? longint'(-longint'(hd)) : longint'(hd);
    a = mag << 14;
    q = a / 64'd1686629713;
    r = a - q * 64'd1686629713;
    r2 = (r * r) >> 30;
    sv = (series(1'b0, r2) * r) >> 30;
    cv = series(1'b1, r2);
    s = longint'((sv + 64'd8192) >> 14);
    c = longint'((cv + 64'd8192) >> 14);
    case (q[1:0])
      2'd0: begin sn = s;  cs = c;  end
      2'd1: begin sn = c;  cs = -s; end
      2'd2: begin sn = -s; cs = -c; end
      default: begin sn = -c; cs = s; end
    endcase
    if (hd < 0) sn = -sn;
  endtask

  task automatic dead_reckon(input odo_in_t it, output pose_t p);
    longint gap, vf, vs, wr, sn, cs, dx, dy;
    logic [39:0] diff;
    diff = it.stamp - odo_last;
    if (it.kind) begin
      odo_x = it.sx;
      odo_y = it.sy;
      odo_h = fold_heading(longint'(it.sh));
      odo_timed = 0;
      p.st = poi_pkg::ST_POSE;
    end else if (!odo_timed) begin
      odo_last = it.stamp;
      odo_timed = 1;
      p.st = poi_pkg::ST_FIRST;
    end else if (it.stamp <= odo_last || diff > {20'd0, gap_limit}) begin
      odo_last = it.stamp;
      p.st = poi_pkg::ST_GAP;
    end else begin
      gap = longint'(diff);
      vf = it.vf;
      vs = it.vs;
      wr = it.w;
      rotation(odo_h, sn, cs);
      dx = ((vf * cs - vs * sn) * gap) >>> 36;
      dy = ((vf * sn + vs * cs) * gap) >>> 36;
      odo_x = odo_x + dx[39:0];
      odo_y = odo_y + dy[39:0];
      odo_h = fold_heading(longint'(odo_h) + ((wr * gap) >>> 20));
      odo_last = it.stamp;
      p.st = poi_pkg::ST_INTEG;
    end
    p.x = odo_x;
    p.y = odo_y;
    p.h = odo_h;
  endtask

  task automatic write_gap_limit(input logic [19:0] v);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    gap_limit = v;
  endtask

  task automatic send(input odo_in_t it, input bit typed, input pose_t want);
    pose_t p;
    int pause;
    @(negedge clk);
    kind = it.kind;
    vel_fwd = it.vf;
    vel_side = it.vs;
    turn_rate = it.w;
    stamp = it.stamp;
    set_x = it.sx;
    set_y = it.sy;
    set_heading = it.sh;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    dead_reckon(it, p);
    pose_q.push_back(typed ? want : p);
    n_items++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 20);
      pause = $urandom_range(0, gap_max);
      if (pause > 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (pause - 1) @(negedge clk);
      end
    end
  endtask

  task automatic drain;
    @(negedge clk);
    in_valid = 1'b0;
    while (pose_q.size() != 0) @(posedge clk);
  endtask

  task automatic row(input logic k, input logic signed [23:0] vf, input logic signed [23:0] vs,
                     input logic signed [20:0] w, input logic [39:0] st,
                     input logic signed [39:0] sx, input logic signed [39:0] sy,
                     input logic signed [19:0] sh, input bit typed,
                     input logic signed [39:0] ex, input logic signed [39:0] ey,
                     input logic signed [18:0] eh, input logic [1:0] es);
    row_t r;
    r.it = '{k, vf, vs, w, st, sx, sy, sh};
    r.typed = typed;
    r.pose = '{ex, ey, eh, es};
    dir_rows.push_back(r);
  endtask

  function automatic odo_in_t random_item(input logic [39:0] last, input bit timed);
    odo_in_t it;
    int pick;
    logic [39:0] gap;
    it.kind = ($urandom_range(0, 99) < 4);
    pick = $urandom_range(0, 3);
    it.vf = (pick == 0) ? 24'($urandom) : 24'($signed($urandom_range(0, 400000)) - 200000);
    it.vs = (pick == 1) ? 24'($urandom) : 24'($signed($urandom_range(0, 200000)) - 100000);
    it.w  = (pick == 2) ? 21'($urandom) : 21'($signed($urandom_range(0, 200000)) - 100000);
    it.sx = {8'($urandom), 32'($urandom)};
    it.sy = {8'($urandom), 32'($urandom)};
    it.sh = 20'($urandom);
    pick = $urandom_range(0, 99);
    if (!timed) begin
      it.stamp = {8'($urandom), 32'($urandom)};
    end else if (pick < 85) begin
      gap = (gap_limit == 0) ? 40'd1 : 40'($urandom_range(1, gap_limit));
      if ($urandom_range(0, 3) == 0) gap = {20'd0, gap_limit};
      it.stamp = last + gap;
    end else if (pick < 90) begin
      it.stamp = last;
    end else if (pick < 95) begin
      it.stamp = last - 40'($urandom_range(1, 1000));
    end else begin
      it.stamp = last + {20'd0, gap_limit} + 40'($urandom_range(1, 5000));
    end
    return it;
  endfunction

  // receiver stall pattern: switches between always ready and random stalls
  int stall_mode = 0;
  int stall_left = 0;
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(20, 300);
      out_ready <= 1'b1;
    end else begin
      stall_left <= stall_left - 1;
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        default: out_ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    pose_t e;
    if (!rst && out_valid && out_ready) begin
      n_results++;
      status_seen[status]++;
      if (pose_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: x=%0d y=%0d h=%0d st=%0d",
                                       pos_x_out, pos_y_out, heading_out, status);
      end else begin
        e = pose_q.pop_front();
        if (e.x !== pos_x_out || e.y !== pos_y_out || e.h !== heading_out ||
            e.st !== status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected x=%0d y=%0d h=%0d st=%0d, got x=%0d y=%0d h=%0d st=%0d",
                     e.x, e.y, e.h, e.st, pos_x_out, pos_y_out, heading_out, status);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    odo_in_t it;
    pose_t none;
    logic [19:0] limits[6];
    int counts[6];
    none = '{0, 0, 0, poi_pkg::ST_INTEG};
    gap_limit = poi_pkg::MAX_GAP_RESET;
    odo_x = 0;
    odo_y = 0;
    odo_h = 0;
    odo_last = 0;
    odo_timed = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // kind, vf, vs, w, stamp, sx, sy, sh, typed, x, y, h, status
    row(0, 24'sh7FFFFF, 0, 0, 40'd100, 0, 0, 0, 1, 0, 0, 0, poi_pkg::ST_FIRST);
    row(0, 0, 0, 0, 40'd100, 0, 0, 0, 1, 0, 0, 0, poi_pkg::ST_GAP);
    row(0, 0, 0, 0, 40'd99, 0, 0, 0, 1, 0, 0, 0, poi_pkg::ST_GAP);
    row(0, 0, 0, 0, 40'd104958, 0, 0, 0, 1, 0, 0, 0, poi_pkg::ST_GAP);
    row(0, 24'sd65536, 0, 0, 40'd209816, 0, 0, 0, 0, 0, 0, 0, 0);
    row(0, 24'sh7FFFFF, 24'sh800000, 21'sh0FFFFF, 40'd314674, 0, 0, 0, 0, 0, 0, 0, 0);
    row(0, 24'sh800000, 24'sh7FFFFF, 21'sh100000, 40'd314675, 0, 0, 0, 0, 0, 0, 0, 0);
    row(1, 0, 0, 0, 0, 40'sh7FFFFFFFFF, 40'sh8000000000, 20'sd411775, 1,
        40'sh7FFFFFFFFF, 40'sh8000000000, 0, poi_pkg::ST_POSE);
    row(0, 0, 0, 0, 40'd5, 0, 0, 0, 1, 40'sh7FFFFFFFFF, 40'sh8000000000, 0,
        poi_pkg::ST_FIRST);
    row(0, 24'sh7FFFFF, 24'sh7FFFFF, 21'sh0FFFFF, 40'd104863, 0, 0, 0, 0, 0, 0, 0, 0);
    row(1, 0, 0, 0, 0, 0, 0, 20'sh7FFFF, 1, 0, 0, 19'sd112512, poi_pkg::ST_POSE);
    row(1, 24'sh7FFFFF, 0, 0, 40'hFFFFFFFFFF, 0, 0, 20'sh80000, 1, 0, 0, -19'sd112513,
        poi_pkg::ST_POSE);
    row(1, 0, 0, 0, 0, 0, 0, 20'sd205888, 1, 0, 0, -19'sd205887, poi_pkg::ST_POSE);
    row(1, 0, 0, 0, 0, 0, 0, -20'sd205887, 1, 0, 0, -19'sd205887, poi_pkg::ST_POSE);
    row(0, 0, 0, 0, 40'hFFFFFFFFFF, 0, 0, 0, 1, 0, 0, -19'sd205887, poi_pkg::ST_FIRST);
    row(0, 0, 0, 0, 40'd0, 0, 0, 0, 1, 0, 0, -19'sd205887, poi_pkg::ST_GAP);
    row(0, 24'sd300000, -24'sd200000, 21'sh100000, 40'd104858, 0, 0, 0, 0, 0, 0, 0, 0);
    row(1, 0, 0, 0, 0, 0, 0, 20'sd102944, 1, 0, 0, 19'sd102944, poi_pkg::ST_POSE);
    row(0, 0, 0, 0, 40'd0, 0, 0, 0, 1, 0, 0, 19'sd102944, poi_pkg::ST_FIRST);
    row(0, 24'sd65536, 24'sd65536, 21'sd1000, 40'd50000, 0, 0, 0, 0, 0, 0, 0, 0);
    row(1, 0, 0, 0, 0, 0, 0, -20'sd150000, 1, 0, 0, -19'sd150000, poi_pkg::ST_POSE);
    row(0, 0, 0, 0, 40'd7, 0, 0, 0, 1, 0, 0, -19'sd150000, poi_pkg::ST_FIRST);
    row(0, -24'sd70000, 24'sd90000, -21'sd5000, 40'd60007, 0, 0, 0, 0, 0, 0, 0, 0);
    foreach (dir_rows[i]) send(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].pose);
    drain();

    limits = '{20'd1, 20'hFFFFF, 20'($urandom_range(2, 1048574)), 20'd0, 20'd3000,
               poi_pkg::MAX_GAP_RESET};
    counts = '{200, 400, 350, 50, 250, 380};
    for (int ph = 0; ph < 6; ph++) begin
      write_gap_limit(limits[ph]);
      gap_max = (ph == 4) ? 0 : $urandom_range(1, 8);
      for (int n = 0; n < counts[ph]; n++) begin
        it = random_item(odo_last, odo_timed);
        send(it, 0, none);
      end
      drain();
    end

    repeat (200) @(posedge clk);
    $display("%0d items sent, %0d results; integrated %0d, first %0d, rejected %0d, reset %0d",
             n_items, n_results, status_seen[0], status_seen[1], status_seen[2],
             status_seen[3]);
    $display("gap limits exercised: reset value, 0, 1, 3000, full scale and one random");
    if (mismatches == 0 && pose_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pose_q.size());
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/poi_pkg.sv
rtl/poi_ctrl.sv
rtl/poi_datapath.sv
rtl/planar_odometry_integrator.sv
verif/planar_odometry_integrator_test.sv
